// ===== rtl/core/obbpmpa_pkg.sv =====
// Shared types and constants for the oriented box pair penetration axis block.
`default_nettype none

package obbpmpa_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int AXIS_COUNT     = 15;
    localparam int FACE_AXES      = 6;
    localparam int ONE_Q14        = 16384;
    localparam int QPROD_COUNT    = 9;
    localparam int CROSS_STEPS    = 6;
    localparam int SQRT_STEPS     = 31;
    localparam int DIV_STEPS      = 15;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_A,
        OP_LOAD_B,
        OP_QPROD,
        OP_ROT,
        OP_FACE,
        OP_CROSS,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_DIST,
        OP_PEN_INIT,
        OP_DOT,
        OP_RAD,
        OP_CMP,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       box;
        logic [3:0] axis;
        logic [4:0] step;
        logic [1:0] row;
        logic [1:0] col;
    } cmd_t;

    typedef struct packed {
        logic axis_zero;
        logic pen_neg;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/obbpmpa_ctrl.sv =====
// Sequencer for the box pair test: handshakes and datapath command issue.
`default_nettype none

module obbpmpa_ctrl
    import obbpmpa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire logic  slot,
    output logic       out_valid,
    input  wire logic  out_stall,
    output cmd_t       cmd,
    input  wire stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_QPROD,
        S_ROT,
        S_AXIS,
        S_ZCHK,
        S_SQ,
        S_SQRT_I,
        S_SQRT,
        S_DIV_I,
        S_DIV,
        S_DIV_E,
        S_DIST,
        S_PEN_I,
        S_DOT,
        S_RAD,
        S_CMP,
        S_NEXT,
        S_DONE
    } state_t;

    state_t     state_reg;
    logic [4:0] cnt_reg;
    logic [3:0] axis_reg;
    logic       box_reg;
    logic [1:0] row_reg;
    logic [1:0] col_reg;
    logic       loaded_reg;
    logic       out_valid_reg;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd      = '0;
        cmd.op   = OP_NONE;
        cmd.box  = box_reg;
        cmd.axis = axis_reg;
        cmd.step = cnt_reg;
        cmd.row  = row_reg;
        cmd.col  = col_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !slot)
                begin
                    cmd.op = OP_LOAD_A;
                end
                else if (in_valid && loaded_reg)
                begin
                    cmd.op = OP_LOAD_B;
                end
            end
            S_QPROD:  cmd.op = OP_QPROD;
            S_ROT:    cmd.op = OP_ROT;
            S_AXIS:   cmd.op = (axis_reg < 4'(FACE_AXES)) ? OP_FACE : OP_CROSS;
            S_SQ:     cmd.op = OP_SQ;
            S_SQRT_I: cmd.op = OP_SQRT_INIT;
            S_SQRT:   cmd.op = OP_SQRT_STEP;
            S_DIV_I:  cmd.op = OP_DIV_INIT;
            S_DIV:    cmd.op = OP_DIV_STEP;
            S_DIV_E:  cmd.op = OP_DIV_END;
            S_DIST:   cmd.op = OP_DIST;
            S_PEN_I:  cmd.op = OP_PEN_INIT;
            S_DOT:    cmd.op = OP_DOT;
            S_RAD:    cmd.op = OP_RAD;
            S_CMP:    cmd.op = OP_CMP;
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.op = OP_RESULT;
                end
            end
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            axis_reg      <= '0;
            box_reg       <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            loaded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !slot)
                    begin
                        loaded_reg <= 1'b1;
                    end
                    else if (in_valid && loaded_reg)
                    begin
                        box_reg   <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= S_QPROD;
                    end
                end
                S_QPROD:
                begin
                    if (cnt_reg == 5'(QPROD_COUNT - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_ROT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_ROT:
                begin
                    if (!box_reg)
                    begin
                        box_reg   <= 1'b1;
                        state_reg <= S_QPROD;
                    end
                    else
                    begin
                        axis_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_AXIS;
                    end
                end
                S_AXIS:
                begin
                    if (axis_reg < 4'(FACE_AXES))
                    begin
                        state_reg <= S_ZCHK;
                    end
                    else if (cnt_reg == 5'(CROSS_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_ZCHK;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_ZCHK:
                begin
                    row_reg   <= '0;
                    state_reg <= stat.axis_zero ? S_NEXT : S_SQ;
                end
                S_SQ:
                begin
                    if (row_reg == 2'd2)
                    begin
                        row_reg   <= '0;
                        state_reg <= S_SQRT_I;
                    end
                    else
                    begin
                        row_reg <= row_reg + 2'd1;
                    end
                end
                S_SQRT_I:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (cnt_reg == 5'(SQRT_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        row_reg   <= '0;
                        state_reg <= S_DIV_I;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_DIV_I:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == 5'(DIV_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DIV_E;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_DIV_E:
                begin
                    if (row_reg == 2'd2)
                    begin
                        row_reg   <= '0;
                        state_reg <= S_DIST;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 2'd1;
                        state_reg <= S_DIV_I;
                    end
                end
                S_DIST:
                begin
                    if (row_reg == 2'd2)
                    begin
                        row_reg   <= '0;
                        state_reg <= S_PEN_I;
                    end
                    else
                    begin
                        row_reg <= row_reg + 2'd1;
                    end
                end
                S_PEN_I:
                begin
                    box_reg   <= 1'b0;
                    row_reg   <= '0;
                    col_reg   <= '0;
                    state_reg <= S_DOT;
                end
                S_DOT:
                begin
                    if (col_reg == 2'd2)
                    begin
                        col_reg   <= '0;
                        state_reg <= S_RAD;
                    end
                    else
                    begin
                        col_reg <= col_reg + 2'd1;
                    end
                end
                S_RAD:
                begin
                    if (row_reg != 2'd2)
                    begin
                        row_reg   <= row_reg + 2'd1;
                        state_reg <= S_DOT;
                    end
                    else if (!box_reg)
                    begin
                        box_reg   <= 1'b1;
                        row_reg   <= '0;
                        state_reg <= S_DOT;
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= stat.pen_neg ? S_DONE : S_NEXT;
                end
                S_NEXT:
                begin
                    if (axis_reg == 4'(AXIS_COUNT - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 4'd1;
                        cnt_reg   <= '0;
                        state_reg <= S_AXIS;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/obbpmpa_dp.sv =====
// Datapath for the box pair test: box store, shared multiplier, root and divide.
`default_nettype none

module obbpmpa_dp
    import obbpmpa_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cmd_t                         cmd,
    output stat_t                             stat,
    input  wire logic signed [COORD_BITS-1:0] center_x,
    input  wire logic signed [COORD_BITS-1:0] center_y,
    input  wire logic signed [COORD_BITS-1:0] center_z,
    input  wire logic        [COORD_BITS-2:0] half_x,
    input  wire logic        [COORD_BITS-2:0] half_y,
    input  wire logic        [COORD_BITS-2:0] half_z,
    input  wire logic signed [15:0]           quat_w,
    input  wire logic signed [15:0]           quat_x,
    input  wire logic signed [15:0]           quat_y,
    input  wire logic signed [15:0]           quat_z,
    output logic signed [15:0]                normal_x,
    output logic signed [15:0]                normal_y,
    output logic signed [15:0]                normal_z,
    output logic                              overlapping
);

    localparam int CW  = COORD_BITS;
    localparam int HW  = COORD_BITS - 1;
    localparam int DW  = COORD_BITS + 1;
    localparam int MA  = (COORD_BITS + 2 > 31) ? COORD_BITS + 2 : 31;
    localparam int MB  = 31;
    localparam int PRW = MA + MB;
    localparam int PW  = COORD_BITS + 8;

    logic signed [CW-1:0] a_c_reg [3];
    logic signed [CW-1:0] b_c_reg [3];
    logic        [HW-1:0] a_h_reg [3];
    logic        [HW-1:0] b_h_reg [3];
    logic signed [15:0]   a_q_reg [4];
    logic signed [15:0]   b_q_reg [4];
    logic signed [31:0]   prod_reg [QPROD_COUNT];
    logic signed [15:0]   rot_a_reg [3][3];
    logic signed [15:0]   rot_b_reg [3][3];
    logic signed [30:0]   v_reg [3];
    logic        [61:0]   sq_reg;
    logic        [61:0]   srem_reg;
    logic        [61:0]   sres_reg;
    logic        [61:0]   sbit_reg;
    logic        [46:0]   drem_reg;
    logic        [46:0]   dsh_reg;
    logic        [14:0]   quo_reg;
    logic signed [15:0]   n_reg [3];
    logic signed [31:0]   dot_reg;
    logic signed [PW-1:0] dist_reg;
    logic signed [PW-1:0] pen_reg;
    logic signed [PW-1:0] best_reg;
    logic signed [15:0]   best_n_reg [3];
    logic                 found_reg;
    logic                 sep_reg;
    logic signed [15:0]   normal_x_reg;
    logic signed [15:0]   normal_y_reg;
    logic signed [15:0]   normal_z_reg;
    logic                 overlap_reg;

    logic signed [MA-1:0]  ma;
    logic signed [MB-1:0]  mb;
    logic signed [PRW-1:0] prd;
    logic signed [PRW-1:0] dist_term;
    logic signed [PRW-1:0] rad_term;
    logic [1:0]            a_row;
    logic [1:0]            a_col;
    logic [1:0]            b_row;
    logic [1:0]            b_col;
    logic [3:0]            cr_sel;
    logic [1:0]            cr_i;
    logic [1:0]            cr_j;
    logic [1:0]            cr_c;
    logic [3:0]            qsel;
    logic signed [15:0]    qa;
    logic signed [15:0]    qb;
    logic signed [15:0]    ra;
    logic signed [15:0]    rb;
    logic signed [31:0]    dot_rnd;
    logic [16:0]           dot_mag;
    logic [61:0]           sqrt_trial;
    logic                  best_upd;

    function automatic logic [1:0] add3(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        add3 = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    function automatic logic [3:0] qpair(input logic [3:0] idx);
        logic [3:0] r;
        unique case (idx)
            4'd0:    r = {2'd2, 2'd2};
            4'd1:    r = {2'd3, 2'd3};
            4'd2:    r = {2'd1, 2'd2};
            4'd3:    r = {2'd3, 2'd0};
            4'd4:    r = {2'd1, 2'd3};
            4'd5:    r = {2'd2, 2'd0};
            4'd6:    r = {2'd1, 2'd1};
            4'd7:    r = {2'd2, 2'd3};
            4'd8:    r = {2'd1, 2'd0};
            default: r = '0;
        endcase
        qpair = r;
    endfunction

    function automatic logic [3:0] cross_sel(input logic [3:0] k);
        logic [3:0] r;
        unique case (k)
            4'd6:    r = {2'd0, 2'd0};
            4'd7:    r = {2'd0, 2'd1};
            4'd8:    r = {2'd0, 2'd2};
            4'd9:    r = {2'd1, 2'd0};
            4'd10:   r = {2'd1, 2'd1};
            4'd11:   r = {2'd1, 2'd2};
            4'd12:   r = {2'd2, 2'd0};
            4'd13:   r = {2'd2, 2'd1};
            4'd14:   r = {2'd2, 2'd2};
            default: r = '0;
        endcase
        cross_sel = r;
    endfunction

    function automatic logic signed [PRW-1:0] rnd_prd(input logic signed [PRW-1:0] v);
        logic [PRW-1:0] m;
        m = v[PRW-1] ? (~v + 1'b1) : v;
        m = (m + PRW'(8192)) >> 14;
        rnd_prd = v[PRW-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [34:0] rnd35(input logic signed [34:0] v);
        logic [34:0] m;
        m = v[34] ? (~v + 1'b1) : v;
        m = (m + 35'd8192) >> 14;
        rnd35 = v[34] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] rnd32(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 1'b1) : v;
        m = (m + 32'd8192) >> 14;
        rnd32 = v[31] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [29:0] vmag(input logic signed [30:0] v);
        logic [30:0] m;
        m = v[30] ? (~v + 1'b1) : v;
        vmag = m[29:0];
    endfunction

    function automatic logic signed [15:0] rot_entry(
        input logic signed [31:0] pa,
        input logic signed [31:0] pb,
        input logic               neg,
        input logic               diag
    );
        logic signed [34:0] s;
        logic signed [34:0] r;
        logic signed [34:0] e;
        s = neg ? (35'(pa) - 35'(pb)) : (35'(pa) + 35'(pb));
        s = s <<< 1;
        r = rnd35(s);
        e = diag ? (35'(ONE_Q14) - r) : r;
        if (e > 35'(ONE_Q14))
        begin
            rot_entry = 16'(ONE_Q14);
        end
        else if (e < -35'(ONE_Q14))
        begin
            rot_entry = -16'(ONE_Q14);
        end
        else
        begin
            rot_entry = e[15:0];
        end
    endfunction

    assign cr_sel = cross_sel(cmd.axis);
    assign cr_i   = cr_sel[3:2];
    assign cr_j   = cr_sel[1:0];
    assign cr_c   = cmd.step[2:1];
    assign qsel   = qpair(cmd.step[3:0]);
    assign qa     = cmd.box ? b_q_reg[qsel[3:2]] : a_q_reg[qsel[3:2]];
    assign qb     = cmd.box ? b_q_reg[qsel[1:0]] : a_q_reg[qsel[1:0]];

    always_comb
    begin
        a_row = cmd.row;
        a_col = cmd.col;
        b_row = cmd.row;
        b_col = cmd.col;
        unique case (cmd.op)
            OP_FACE:
            begin
                a_row = (cmd.axis < 4'd3) ? cmd.axis[1:0] : 2'd0;
                b_row = (cmd.axis < 4'd3) ? 2'd0 : 2'(cmd.axis - 4'd3);
            end
            OP_CROSS:
            begin
                a_row = cr_i;
                b_row = cr_j;
                a_col = cmd.step[0] ? add3(cr_c, 2'd2) : add3(cr_c, 2'd1);
                b_col = cmd.step[0] ? add3(cr_c, 2'd1) : add3(cr_c, 2'd2);
            end
            default:
            begin
                a_row = cmd.row;
            end
        endcase
    end

    assign ra      = rot_a_reg[a_row][a_col];
    assign rb      = rot_b_reg[b_row][b_col];
    assign dot_rnd = rnd32(dot_reg);
    assign dot_mag = dot_rnd[31] ? 17'(-dot_rnd) : dot_rnd[16:0];

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            OP_QPROD:
            begin
                ma = MA'(qa);
                mb = MB'(qb);
            end
            OP_CROSS:
            begin
                ma = MA'(ra);
                mb = MB'(rb);
            end
            OP_SQ:
            begin
                ma = MA'({1'b0, vmag(v_reg[cmd.row])});
                mb = MB'({1'b0, vmag(v_reg[cmd.row])});
            end
            OP_DIST:
            begin
                ma = MA'(DW'(a_c_reg[cmd.row]) - DW'(b_c_reg[cmd.row]));
                mb = MB'(n_reg[cmd.row]);
            end
            OP_DOT:
            begin
                ma = MA'(n_reg[cmd.col]);
                mb = cmd.box ? MB'(rb) : MB'(ra);
            end
            OP_RAD:
            begin
                ma = cmd.box ? MA'({1'b0, b_h_reg[cmd.row]}) : MA'({1'b0, a_h_reg[cmd.row]});
                mb = MB'({1'b0, dot_mag});
            end
            default:
            begin
                ma = '0;
            end
        endcase
    end

    assign prd        = ma * mb;
    assign dist_term  = rnd_prd(prd);
    assign rad_term   = (prd + PRW'(8192)) >>> 14;
    assign sqrt_trial = sres_reg + sbit_reg;
    assign best_upd   = !pen_reg[PW-1] && (!found_reg || (pen_reg < best_reg));

    assign stat.axis_zero = (v_reg[0] == '0) && (v_reg[1] == '0) && (v_reg[2] == '0);
    assign stat.pen_neg   = pen_reg[PW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            sep_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_LOAD_B)
            begin
                found_reg <= 1'b0;
                sep_reg   <= 1'b0;
            end
            else if (cmd.op == OP_CMP)
            begin
                if (pen_reg[PW-1])
                begin
                    sep_reg <= 1'b1;
                end
                else if (best_upd)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD_A:
            begin
                a_c_reg[0] <= center_x;
                a_c_reg[1] <= center_y;
                a_c_reg[2] <= center_z;
                a_h_reg[0] <= half_x;
                a_h_reg[1] <= half_y;
                a_h_reg[2] <= half_z;
                a_q_reg[0] <= quat_w;
                a_q_reg[1] <= quat_x;
                a_q_reg[2] <= quat_y;
                a_q_reg[3] <= quat_z;
            end
            OP_LOAD_B:
            begin
                b_c_reg[0] <= center_x;
                b_c_reg[1] <= center_y;
                b_c_reg[2] <= center_z;
                b_h_reg[0] <= half_x;
                b_h_reg[1] <= half_y;
                b_h_reg[2] <= half_z;
                b_q_reg[0] <= quat_w;
                b_q_reg[1] <= quat_x;
                b_q_reg[2] <= quat_y;
                b_q_reg[3] <= quat_z;
                for (int i = 0; i < 3; i++)
                begin
                    best_n_reg[i] <= '0;
                end
            end
            OP_QPROD:
            begin
                prod_reg[cmd.step[3:0]] <= prd[31:0];
            end
            OP_ROT:
            begin
                if (cmd.box)
                begin
                    rot_b_reg[0][0] <= rot_entry(prod_reg[0], prod_reg[1], 1'b0, 1'b1);
                    rot_b_reg[0][1] <= rot_entry(prod_reg[2], prod_reg[3], 1'b0, 1'b0);
                    rot_b_reg[0][2] <= rot_entry(prod_reg[4], prod_reg[5], 1'b1, 1'b0);
                    rot_b_reg[1][0] <= rot_entry(prod_reg[2], prod_reg[3], 1'b1, 1'b0);
                    rot_b_reg[1][1] <= rot_entry(prod_reg[6], prod_reg[1], 1'b0, 1'b1);
                    rot_b_reg[1][2] <= rot_entry(prod_reg[7], prod_reg[8], 1'b0, 1'b0);
                    rot_b_reg[2][0] <= rot_entry(prod_reg[4], prod_reg[5], 1'b0, 1'b0);
                    rot_b_reg[2][1] <= rot_entry(prod_reg[7], prod_reg[8], 1'b1, 1'b0);
                    rot_b_reg[2][2] <= rot_entry(prod_reg[6], prod_reg[0], 1'b0, 1'b1);
                end
                else
                begin
                    rot_a_reg[0][0] <= rot_entry(prod_reg[0], prod_reg[1], 1'b0, 1'b1);
                    rot_a_reg[0][1] <= rot_entry(prod_reg[2], prod_reg[3], 1'b0, 1'b0);
                    rot_a_reg[0][2] <= rot_entry(prod_reg[4], prod_reg[5], 1'b1, 1'b0);
                    rot_a_reg[1][0] <= rot_entry(prod_reg[2], prod_reg[3], 1'b1, 1'b0);
                    rot_a_reg[1][1] <= rot_entry(prod_reg[6], prod_reg[1], 1'b0, 1'b1);
                    rot_a_reg[1][2] <= rot_entry(prod_reg[7], prod_reg[8], 1'b0, 1'b0);
                    rot_a_reg[2][0] <= rot_entry(prod_reg[4], prod_reg[5], 1'b0, 1'b0);
                    rot_a_reg[2][1] <= rot_entry(prod_reg[7], prod_reg[8], 1'b1, 1'b0);
                    rot_a_reg[2][2] <= rot_entry(prod_reg[6], prod_reg[0], 1'b0, 1'b1);
                end
            end
            OP_FACE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cmd.axis < 4'd3)
                    begin
                        v_reg[i] <= {rot_a_reg[a_row][i][15], rot_a_reg[a_row][i], 14'd0};
                    end
                    else
                    begin
                        v_reg[i] <= {rot_b_reg[b_row][i][15], rot_b_reg[b_row][i], 14'd0};
                    end
                end
            end
            OP_CROSS:
            begin
                if (cmd.step[0])
                begin
                    v_reg[cr_c] <= v_reg[cr_c] - prd[30:0];
                end
                else
                begin
                    v_reg[cr_c] <= prd[30:0];
                end
            end
            OP_SQ:
            begin
                sq_reg <= ((cmd.row == 2'd0) ? 62'd0 : sq_reg) + prd[61:0];
            end
            OP_SQRT_INIT:
            begin
                srem_reg <= sq_reg;
                sres_reg <= '0;
                sbit_reg <= 62'd1 << 60;
            end
            OP_SQRT_STEP:
            begin
                if (srem_reg >= sqrt_trial)
                begin
                    srem_reg <= srem_reg - sqrt_trial;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            OP_DIV_INIT:
            begin
                drem_reg <= {2'b00, vmag(v_reg[cmd.row]), 15'd0} + 47'(sres_reg[30:0]);
                dsh_reg  <= {1'b0, sres_reg[30:0], 15'd0};
                quo_reg  <= '0;
            end
            OP_DIV_STEP:
            begin
                if (drem_reg >= dsh_reg)
                begin
                    drem_reg <= drem_reg - dsh_reg;
                    quo_reg  <= {quo_reg[13:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[13:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            OP_DIV_END:
            begin
                n_reg[cmd.row] <= v_reg[cmd.row][30] ? -$signed({1'b0, quo_reg})
                                                     : $signed({1'b0, quo_reg});
            end
            OP_DIST:
            begin
                dist_reg <= ((cmd.row == 2'd0) ? PW'(0) : dist_reg) + dist_term[PW-1:0];
            end
            OP_PEN_INIT:
            begin
                pen_reg <= dist_reg[PW-1] ? dist_reg : -dist_reg;
            end
            OP_DOT:
            begin
                dot_reg <= ((cmd.col == 2'd0) ? 32'sd0 : dot_reg) + prd[31:0];
            end
            OP_RAD:
            begin
                pen_reg <= pen_reg + rad_term[PW-1:0];
            end
            OP_CMP:
            begin
                if (best_upd)
                begin
                    best_reg <= pen_reg;
                    for (int i = 0; i < 3; i++)
                    begin
                        best_n_reg[i] <= n_reg[i];
                    end
                end
            end
            OP_RESULT:
            begin
                normal_x_reg <= sep_reg ? 16'sd0 : best_n_reg[0];
                normal_y_reg <= sep_reg ? 16'sd0 : best_n_reg[1];
                normal_z_reg <= sep_reg ? 16'sd0 : best_n_reg[2];
                overlap_reg  <= !sep_reg;
            end
            default:
            begin
                overlap_reg <= overlap_reg;
            end
        endcase
    end

    assign normal_x    = normal_x_reg;
    assign normal_y    = normal_y_reg;
    assign normal_z    = normal_z_reg;
    assign overlapping = overlap_reg;

endmodule

`default_nettype wire

// ===== rtl/core/obb_pair_min_penetration_axis_top.sv =====
// Top level of the oriented box pair minimum penetration axis block.
// Input channel (in_valid/in_stall): one box per word. A word with slot 0
// stores the first box and yields no result. A word with slot 1
// supplies the second box and starts the test; it is dropped without result
// if no first box has been stored since reset.
// Output channel (out_valid/out_stall): one result word per test, held in an
// output register until taken; the next box word is taken while it waits.
// A test first builds both rotations, then tests the axes in turn, skipping
// any zero axis, and moves the result to the output register. The sequencer
// stops at the first axis with negative overlap. The test time is set by the
// single shared multiplier, the one-bit-a-cycle square root (31 steps) and
// the one-bit-a-cycle divider (15 steps per component).
// in_stall is high for the whole test, and a finished result also waits in
// the sequencer while the output register is full and out_stall is high.
// Reset clears the sequencer, the stored-box flag and the output valid.
`default_nettype none

module obb_pair_min_penetration_axis_top
    import obbpmpa_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         slot,
    input  wire logic signed [COORD_BITS-1:0] center_x,
    input  wire logic signed [COORD_BITS-1:0] center_y,
    input  wire logic signed [COORD_BITS-1:0] center_z,
    input  wire logic        [COORD_BITS-2:0] half_x,
    input  wire logic        [COORD_BITS-2:0] half_y,
    input  wire logic        [COORD_BITS-2:0] half_z,
    input  wire logic signed [15:0]           quat_w,
    input  wire logic signed [15:0]           quat_x,
    input  wire logic signed [15:0]           quat_y,
    input  wire logic signed [15:0]           quat_z,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [15:0]                normal_x,
    output logic signed [15:0]                normal_y,
    output logic signed [15:0]                normal_z,
    output logic                              overlapping
);

    cmd_t  cmd;
    stat_t stat;

    obbpmpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .slot      (slot),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    obbpmpa_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .half_x      (half_x),
        .half_y      (half_y),
        .half_z      (half_z),
        .quat_w      (quat_w),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .overlapping (overlapping)
    );

endmodule

`default_nettype wire

// ===== bench/tb_obb_pair_min_penetration_axis_top.sv =====
// Self-checking bench for the oriented box pair minimum penetration axis block.
`timescale 1ns / 1ps

module tb_obb_pair_min_penetration_axis_top;
    import obbpmpa_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int HB = CB - 1;
    localparam int RANDOM_WORDS = 640;
    localparam int DRAIN_CYCLES = 2500;

    typedef struct {
        logic                 slot;
        logic signed [CB-1:0] ctr [3];
        logic [CB-2:0]        hlf [3];
        logic signed [15:0]   q [4];
    } box_t;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               ovl;
    } contact_t;

    typedef struct {
        box_t     b;
        bit       typed;
        contact_t r;
    } vector_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 slot;
    logic signed [CB-1:0] center_x, center_y, center_z;
    logic [CB-2:0]        half_x, half_y, half_z;
    logic signed [15:0]   quat_w, quat_x, quat_y, quat_z;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [15:0]   normal_x, normal_y, normal_z;
    logic                 overlapping;

    obb_pair_min_penetration_axis_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .slot(slot),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .half_x(half_x), .half_y(half_y), .half_z(half_z),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .overlapping(overlapping)
    );

    contact_t contact_q [$];
    int       errors = 0;
    int       tests_seen = 0;
    int       seps_seen = 0;
    int       words_sent = 0;

    longint held_ctr [3];
    longint held_hlf [3];
    longint held_q [4];
    bit     held_loaded = 0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint absval(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        longint m;
        m = (absval(v) + (longint'(1) << (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > ONE_Q14)
            return ONE_Q14;
        if (v < -ONE_Q14)
            return -ONE_Q14;
        return v;
    endfunction

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return longint'(res);
    endfunction

    task automatic rotation(input longint q [4], output longint r [3][3]);
        longint w, x, y, z;
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        r[0][0] = ONE_Q14 - round_shift(2 * (y * y + z * z), 14);
        r[0][1] = round_shift(2 * (x * y + z * w), 14);
        r[0][2] = round_shift(2 * (x * z - y * w), 14);
        r[1][0] = round_shift(2 * (x * y - z * w), 14);
        r[1][1] = ONE_Q14 - round_shift(2 * (x * x + z * z), 14);
        r[1][2] = round_shift(2 * (y * z + x * w), 14);
        r[2][0] = round_shift(2 * (x * z + y * w), 14);
        r[2][1] = round_shift(2 * (y * z - x * w), 14);
        r[2][2] = ONE_Q14 - round_shift(2 * (x * x + y * y), 14);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r[i][j] = clamp_unit(r[i][j]);
    endtask

    function automatic longint proj_radius(input longint r [3][3], input longint h [3],
                                           input longint n [3]);
        longint sum, d;
        longint unsigned p;
        sum = 0;
        for (int m = 0; m < 3; m++)
        begin
            d = round_shift(n[0] * r[m][0] + n[1] * r[m][1] + n[2] * r[m][2], 14);
            p = longint'(absval(d)) * h[m];
            sum += longint'((p + 64'd8192) >> 14);
        end
        return sum;
    endfunction

    // Store the first box or test the second; returns 1 when a result is due.
    task automatic predict_contact(input box_t b, output bit due, output contact_t res);
        longint ra [3][3], rb [3][3];
        longint bc [3], bh [3], bq [4];
        longint v [3], n [3], best_n [3];
        longint best, ctr_gap, pen;
        longint unsigned len, m;
        bit found;
        int pa, sb;
        for (int i = 0; i < 3; i++)
        begin
            bc[i] = b.ctr[i];
            bh[i] = longint'(b.hlf[i]);
        end
        for (int i = 0; i < 4; i++)
            bq[i] = b.q[i];
        res = '0;
        due = 0;
        if (!b.slot)
        begin
            held_ctr = bc;
            held_hlf = bh;
            held_q = bq;
            held_loaded = 1;
            return;
        end
        if (!held_loaded)
            return;
        due = 1;
        rotation(held_q, ra);
        rotation(bq, rb);
        found = 0;
        best = 0;
        best_n = '{0, 0, 0};
        for (int k = 0; k < AXIS_COUNT; k++)
        begin
            if (k < FACE_AXES)
            begin
                for (int i = 0; i < 3; i++)
                    v[i] = (k < 3 ? ra[k][i] : rb[k - 3][i]) * ONE_Q14;
            end
            else
            begin
                pa = (k - FACE_AXES) / 3;
                sb = (k - FACE_AXES) % 3;
                v[0] = ra[pa][1] * rb[sb][2] - ra[pa][2] * rb[sb][1];
                v[1] = ra[pa][2] * rb[sb][0] - ra[pa][0] * rb[sb][2];
                v[2] = ra[pa][0] * rb[sb][1] - ra[pa][1] * rb[sb][0];
            end
            if (v[0] == 0 && v[1] == 0 && v[2] == 0)
                continue;
            len = floor_sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
            for (int i = 0; i < 3; i++)
            begin
                m = (longint'(absval(v[i])) * 64'd32768 + len) / (64'd2 * len);
                n[i] = v[i] < 0 ? -longint'(m) : longint'(m);
            end
            ctr_gap = 0;
            for (int i = 0; i < 3; i++)
                ctr_gap += round_shift((held_ctr[i] - bc[i]) * n[i], 14);
            ctr_gap = absval(ctr_gap);
            pen = proj_radius(ra, held_hlf, n) + proj_radius(rb, bh, n) - ctr_gap;
            if (pen < 0)
                return;
            if (!found || pen < best)
            begin
                found = 1;
                best = pen;
                best_n = n;
            end
        end
        res.nx = best_n[0][15:0];
        res.ny = best_n[1][15:0];
        res.nz = best_n[2][15:0];
        res.ovl = 1'b1;
    endtask

    function automatic box_t make_box(input logic s, input longint cx, cy, cz,
                                      input longint hx, hy, hz,
                                      input longint qw, qx, qy, qz);
        box_t b;
        b.slot = s;
        b.ctr = '{cx[CB-1:0], cy[CB-1:0], cz[CB-1:0]};
        b.hlf = '{hx[CB-2:0], hy[CB-2:0], hz[CB-2:0]};
        b.q = '{qw[15:0], qx[15:0], qy[15:0], qz[15:0]};
        return b;
    endfunction

    function automatic longint rand_signed(input longint lim);
        return longint'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic box_t random_box(input logic s);
        box_t b;
        real a [4];
        real nrm;
        int kind;
        b.slot = s;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
        begin
            if (kind == 0)
            begin
                b.ctr[i] = CB'($urandom);
                b.hlf[i] = HB'($urandom);
            end
            else
            begin
                b.ctr[i] = CB'(rand_signed(longint'(8) << 16));
                b.hlf[i] = HB'($urandom_range(0, 6 << 16));
            end
        end
        if (kind == 1)
        begin
            for (int i = 0; i < 4; i++)
                b.q[i] = 16'(rand_signed(ONE_Q14));
        end
        else
        begin
            nrm = 0.0;
            for (int i = 0; i < 4; i++)
            begin
                a[i] = real'(rand_signed(ONE_Q14));
                nrm += a[i] * a[i];
            end
            nrm = $sqrt(nrm);
            for (int i = 0; i < 4; i++)
                b.q[i] = 16'(nrm < 1.0 ? (i == 0 ? ONE_Q14 : 0)
                                       : $rtoi(a[i] / nrm * 16384.0));
        end
        return b;
    endfunction

    task automatic send_word(input box_t b, input bit typed, input contact_t want);
        int gap;
        bit due;
        contact_t got;
        gap = ((words_sent / 40) % 4 == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        slot <= b.slot;
        center_x <= b.ctr[0]; center_y <= b.ctr[1]; center_z <= b.ctr[2];
        half_x <= b.hlf[0]; half_y <= b.hlf[1]; half_z <= b.hlf[2];
        quat_w <= b.q[0]; quat_x <= b.q[1]; quat_y <= b.q[2]; quat_z <= b.q[3];
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_contact(b, due, got);
        if (due)
            contact_q.insert(contact_q.size(), typed ? want : got);
        words_sent++;
    endtask

    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            stall_left <= ((tests_seen / 30) % 3 == 0) ? 0 : $urandom_range(0, 14);
            out_stall <= ((tests_seen / 30) % 3 != 0);
        end
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else
        begin
            stall_left <= 0;
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            contact_t want;
            contact_t got;
            got = '{normal_x, normal_y, normal_z, overlapping};
            tests_seen++;
            if (!got.ovl)
                seps_seen++;
            if (contact_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = contact_q.pop_front();
                if (got.nx !== want.nx)
                    $display("%0t: normal_x expected %0d got %0d", $time, want.nx, got.nx);
                if (got.ny !== want.ny)
                    $display("%0t: normal_y expected %0d got %0d", $time, want.ny, got.ny);
                if (got.nz !== want.nz)
                    $display("%0t: normal_z expected %0d got %0d", $time, want.nz, got.nz);
                if (got.ovl !== want.ovl)
                    $display("%0t: overlapping expected %0b got %0b", $time,
                             want.ovl, got.ovl);
                if (got !== want)
                    errors++;
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("tb_obb_pair_min_penetration_axis_top NOT OK");
        $finish;
    end

    initial
    begin
        vector_t  vec [$];
        vector_t  v;
        contact_t none;
        int       drain;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        slot = 1'b0;
        {center_x, center_y, center_z} = '0;
        {half_x, half_y, half_z} = '0;
        {quat_w, quat_x, quat_y, quat_z} = '0;

        // second box before any first box: dropped
        vec.insert(vec.size(), '{make_box(1, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16,
                                 ONE_Q14, 0, 0, 0), 0, none});
        vec.insert(vec.size(), '{make_box(0, 0, 0, 0, 1 << 16, 2 << 16, 3 << 16,
                                 ONE_Q14, 0, 0, 0), 0, none});
        vec.insert(vec.size(), '{make_box(1, 0, 0, 0, 1 << 16, 2 << 16, 3 << 16,
                                 ONE_Q14, 0, 0, 0), 1, '{16'sd16384, 16'sd0, 16'sd0, 1'b1}});
        vec.insert(vec.size(), '{make_box(1, 0, 0, 0, 1 << 16, 2 << 16, 3 << 16,
                                 ONE_Q14, 0, 0, 0), 1, '{16'sd16384, 16'sd0, 16'sd0, 1'b1}});
        vec.insert(vec.size(), '{make_box(1, 100 << 16, 0, 0, 1 << 16, 2 << 16, 3 << 16,
                                 ONE_Q14, 0, 0, 0), 1, none});
        vec.insert(vec.size(), '{make_box(1, 1 << 15, 1 << 14, 0, 1 << 16, 1 << 16, 1 << 16,
                                 11585, 0, 0, 11585), 0, none});
        vec.insert(vec.size(), '{make_box(1, 0, 1 << 16, 1 << 16, 2 << 16, 1 << 16, 1 << 16,
                                 11585, 11585, 0, 0), 0, none});
        vec.insert(vec.size(), '{make_box(1, -3 << 16, 1 << 16, 0, 3 << 16, 1 << 16, 1 << 16,
                                 8192, 8192, 8192, 8192), 0, none});
        vec.insert(vec.size(), '{make_box(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
        vec.insert(vec.size(), '{make_box(1, 2147483647, -2147483648, 2147483647,
                                 2147483647, 2147483647, 2147483647,
                                 -16384, -16384, -16384, -16384), 0, none});
        vec.insert(vec.size(), '{make_box(1, 0, 0, 0, 2147483647, 2147483647, 2147483647,
                                 16384, 16384, 16384, 16384), 0, none});
        vec.insert(vec.size(), '{make_box(0, -2147483648, -2147483648, -2147483648,
                                 2147483647, 2147483647, 2147483647,
                                 -16384, 16384, -16384, 16384), 0, none});
        vec.insert(vec.size(), '{make_box(1, 2147483647, 2147483647, 2147483647,
                                 2147483647, 2147483647, 2147483647,
                                 16384, -16384, 16384, -16384), 0, none});
        vec.insert(vec.size(), '{make_box(1, -2147483648, -2147483648, -2147483648, 0, 0, 0,
                                 0, 0, 0, -16384), 0, none});
        vec.insert(vec.size(), '{make_box(0, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16,
                                 11585, 0, 11585, 0), 0, none});
        vec.insert(vec.size(), '{make_box(1, 1 << 16, 0, 0, 1 << 16, 1 << 16, 1 << 16,
                                 ONE_Q14, 0, 0, 0), 0, none});
        vec.insert(vec.size(), '{make_box(1, 1 << 16, 0, 0, 1 << 16, 1 << 16, 1 << 16,
                                 0, 0, ONE_Q14, 0), 0, none});
        vec.insert(vec.size(), '{make_box(1, 0, 1 << 16, -1 << 16, 1 << 16, 1 << 16, 1 << 16,
                                 100, -16000, 3000, 200), 0, none});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vec[i])
            send_word(vec[i].b, vec[i].typed, vec[i].r);
        for (int i = 0; i < RANDOM_WORDS; i++)
            send_word(random_box($urandom_range(0, 3) == 0 ? 1'b0 : 1'b1), 0, none);
        in_valid <= 1'b0;

        drain = 0;
        while (contact_q.size() != 0 && drain < 100_000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (contact_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, contact_q.size());
            errors++;
        end
        $display("%0d box words sent, %0d tests checked (%0d separated)",
                 words_sent, tests_seen, seps_seen);
        if (errors == 0)
            $display("tb_obb_pair_min_penetration_axis_top OK");
        else
            $display("tb_obb_pair_min_penetration_axis_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/obbpmpa_pkg.sv
rtl/core/obbpmpa_ctrl.sv
rtl/core/obbpmpa_dp.sv
rtl/core/obb_pair_min_penetration_axis_top.sv
bench/tb_obb_pair_min_penetration_axis_top.sv
